### hdl/ordered_multiset_store_defines.svh
// Assertion macros used by the top block to check its own behavior.
`ifndef ORDERED_MULTISET_STORE_DEFINES_SVH
`define ORDERED_MULTISET_STORE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define OMS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define OMS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/oms_pkg.sv
package oms_pkg;

   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [1:0] CMD_VALUE = 2'd0;
   localparam logic [1:0] CMD_FLUSH = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]               cmd;
      logic signed [DATA_W-1:0] value;
      logic                     add_mode;
   } oms_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_value;
      logic                     last;
      logic                     dropped;
   } oms_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_REMOVE = 4'b0010,
      ST_FLUSH  = 4'b0100,
      ST_DROP   = 4'b1000
   } oms_state_type;

   // Operations the controller asks of the datapath
   typedef struct packed {
      logic load;
      logic append;
      logic clear;
      logic scan_start;
      logic remove_step;
      logic remove_end;
      logic flush_step;
      logic drop_load;
   } oms_cmd_type;

   typedef struct packed {
      logic full;
      logic pass_done;
      logic out_free;
   } oms_sts_type;

endpackage

### hdl/oms_ctrl.sv
module oms_ctrl
   import oms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  oms_req_type req_payload,
   input  oms_sts_type sts,
   output oms_cmd_type cmd
);

   oms_state_type state_ff, state_in;
   logic          accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               case (req_payload.cmd)
                  CMD_VALUE: begin
                     if (req_payload.add_mode) begin
                        if (sts.full) begin
                           state_in = ST_DROP;
                        end else begin
                           cmd.append = 1'b1;
                        end
                     end else begin
                        cmd.scan_start = 1'b1;
                        state_in       = ST_REMOVE;
                     end
                  end
                  CMD_FLUSH: begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_FLUSH;
                  end
                  CMD_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_REMOVE: begin
            cmd.remove_step = 1'b1;
            if (sts.pass_done) begin
               cmd.remove_end = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            cmd.flush_step = 1'b1;
            if (sts.pass_done) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_DROP: begin
            // hold the rejected value until the result register frees up
            if (sts.out_free) begin
               cmd.drop_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/oms_dpath.sv
module oms_dpath
   import oms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  oms_req_type req_payload,
   input  oms_cmd_type cmd,
   output oms_sts_type sts,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output oms_rsp_type rsp_payload
);

   logic [DATA_W-1:0]        mem [CAPACITY];
   logic [DATA_W-1:0]        rd_data_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [IDX_W-1:0]         rd_idx_ff, rd_idx_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic                     found_ff, found_in;
   logic signed [DATA_W-1:0] value_ff;
   oms_rsp_type              out_ff, out_in;
   logic                     out_valid_ff, out_valid_in;

   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [DATA_W-1:0]        wr_data;
   logic                     issue_ok;
   logic                     out_free;
   logic                     move;
   logic                     is_last;

   assign issue_ok = (idx_ff < count_ff);
   assign out_free = !out_valid_ff || !rsp_stall;
   assign move     = rd_valid_ff && out_free;
   assign rd_addr  = idx_ff[IDX_W-1:0];
   assign is_last  = ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff);

   assign sts.full      = (count_ff == CNT_W'(CAPACITY));
   assign sts.pass_done = !issue_ok && !rd_valid_ff;
   assign sts.out_free  = out_free;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      rd_idx_in    = rd_idx_ff;
      rd_valid_in  = rd_valid_ff;
      found_in     = found_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = req_payload.value;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      if (cmd.scan_start) begin
         idx_in      = '0;
         rd_valid_in = 1'b0;
         found_in    = 1'b0;
      end

      if (cmd.append) begin
         wr_en    = 1'b1;
         count_in = count_ff + CNT_W'(1);
      end

      if (cmd.remove_step) begin
         rd_en       = issue_ok;
         rd_valid_in = issue_ok;
         if (rd_valid_ff) begin
            if (found_ff) begin
               // shift each later entry down one slot over the removed one
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff - IDX_W'(1);
               wr_data = rd_data_ff;
            end else if (rd_data_ff == value_ff) begin
               found_in = 1'b1;
            end
         end
      end

      if (cmd.remove_end && found_ff) begin
         count_in = count_ff - CNT_W'(1);
      end

      if (cmd.flush_step) begin
         if (move) begin
            out_in.out_value = rd_data_ff;
            out_in.last      = is_last;
            out_in.dropped   = 1'b0;
            out_valid_in     = 1'b1;
            rd_valid_in      = 1'b0;
         end
         rd_en = issue_ok && (!rd_valid_ff || move);
         if (rd_en) begin
            rd_valid_in = 1'b1;
         end
      end

      if (rd_en) begin
         idx_in    = idx_ff + CNT_W'(1);
         rd_idx_in = rd_addr;
      end

      if (cmd.drop_load) begin
         out_in.out_value = value_ff;
         out_in.last      = 1'b1;
         out_in.dropped   = 1'b1;
         out_valid_in     = 1'b1;
      end

      if (cmd.clear) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      out_ff    <= out_in;
      if (cmd.load) begin
         value_ff <= req_payload.value;
      end
   end

endmodule

### hdl/ordered_multiset_store.sv
// Add with room and clear complete without leaving idle; the next transaction is accepted in the next cycle.
// Remove and flush scan the entries in insertion order: one read per cycle, flush reads held while a result stalls.
// Flush without stall gives one result per cycle, passing through the read data and result registers.
// Add to a full store passes through the drop state, which loads the drop result once the result register is free.
// A stalled result holds flush and drop; synchronous active-high reset empties the store
// and the result register, leaving memory contents as they were.
module ordered_multiset_store
   import oms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  oms_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output oms_rsp_type rsp_payload
);

   `include "ordered_multiset_store_defines.svh"

   oms_cmd_type cmd;
   oms_sts_type sts;
   logic [4:0]  dp_ops;
   logic        drop_shown;

   assign dp_ops     = {cmd.append, cmd.scan_start, cmd.drop_load, cmd.remove_step,
                        cmd.flush_step};
   assign drop_shown = rsp_valid && rsp_payload.dropped;

   oms_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .sts         (sts),
      .cmd         (cmd)
   );

   oms_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   `OMS_ASSERT(a_no_append_when_full, !(cmd.append && sts.full), "append to a full store")
   `OMS_ASSERT(a_one_operation, $onehot0(dp_ops), "overlapping datapath operations")
   `OMS_ASSERT_NEXT(a_drop_shows, cmd.drop_load, drop_shown && rsp_payload.last, "drop missing")
   `OMS_ASSERT(a_drop_is_last, !drop_shown || rsp_payload.last, "drop result without last")

endmodule

### bench/ordered_multiset_store_test.sv
`timescale 1ns / 100ps

module ordered_multiset_store_test;
   import oms_pkg::*;

   localparam logic [1:0] CMD_SPARE    = 2'd3;
   localparam int         ITEM_TARGET  = 280;
   localparam int         POOL_SIZE    = 8;
   localparam int         DRAIN_CYCLES = 2 * CAPACITY + 20;
   localparam int         CYCLE_LIMIT  = 1000000;

   // Mirror of the store: insertion-ordered contents plus the results still owed.
   class multiset_predictor;
      logic [DATA_W-1:0] held[$];
      oms_rsp_type       awaited[$];
      int                errors = 0;
      int                results_seen = 0;
      int                drop_reports = 0;
      int                flush_bursts = 0;

      function void accept_request(oms_req_type item);
         oms_rsp_type e;
         int          hit;
         case (item.cmd)
            CMD_VALUE: begin
               if (item.add_mode) begin
                  if (held.size() >= CAPACITY) begin
                     e.out_value = item.value;
                     e.last      = 1'b1;
                     e.dropped   = 1'b1;
                     awaited.push_back(e);
                     drop_reports++;
                  end else begin
                     held.push_back(item.value);
                  end
               end else begin
                  hit = -1;
                  for (int i = 0; i < held.size(); i++) begin
                     if (held[i] == item.value) begin
                        hit = i;
                        break;
                     end
                  end
                  if (hit >= 0) held.delete(hit);
               end
            end
            CMD_FLUSH: begin
               if (held.size() > 0) flush_bursts++;
               for (int i = 0; i < held.size(); i++) begin
                  e.out_value = held[i];
                  e.last      = (i == held.size() - 1);
                  e.dropped   = 1'b0;
                  awaited.push_back(e);
               end
               held.delete();
            end
            CMD_CLEAR: held.delete();
            default: ;
         endcase
      endfunction

      function void check_result(oms_rsp_type got);
         oms_rsp_type want;
         results_seen++;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result, got %h", $time, got);
            errors++;
         end else begin
            want = awaited.pop_front();
            if (got.out_value !== want.out_value) begin
               $display("%0t: out_value mismatch, expected %h, got %h",
                        $time, want.out_value, got.out_value);
               errors++;
            end
            if (got.last !== want.last) begin
               $display("%0t: last mismatch, expected %b, got %b", $time, want.last, got.last);
               errors++;
            end
            if (got.dropped !== want.dropped) begin
               $display("%0t: dropped mismatch, expected %b, got %b",
                        $time, want.dropped, got.dropped);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   oms_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   oms_rsp_type rsp_payload;

   multiset_predictor board = new();
   logic [DATA_W-1:0] common_values[POOL_SIZE];
   bit                calm = 1'b0;
   int                items_sent = 0;
   int                stall_left = 0;
   int                cycle_count = 0;

   ordered_multiset_store dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, board.awaited.size());
         $display("ordered_multiset_store regression: fail");
         $finish;
      end
   end

   // Result side: check each result as it is taken, then draw a random stall (none when calm).
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         int wait_cycles;
         wait_cycles = calm ? 0 : $urandom_range(0, 14);
         board.check_result(rsp_payload);
         rsp_stall  <= (wait_cycles != 0);
         stall_left <= wait_cycles;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end
   end

   function automatic oms_req_type make_item(logic [1:0] c, logic [DATA_W-1:0] v, logic a);
      oms_req_type r;
      r.cmd      = c;
      r.value    = v;
      r.add_mode = a;
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] pool_value();
      if ($urandom_range(0, 3) != 0) return common_values[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   // Prefer values that are held so removals actually hit.
   function automatic logic [DATA_W-1:0] removal_value();
      if (board.held.size() > 0 && $urandom_range(0, 9) < 6)
         return board.held[$urandom_range(0, board.held.size() - 1)];
      return pool_value();
   endfunction

   function automatic oms_req_type random_item();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return make_item(CMD_VALUE, pool_value(), 1'b1);
      if (roll < 80) return make_item(CMD_VALUE, removal_value(), 1'b0);
      if (roll < 90) return make_item(CMD_FLUSH, $urandom, 1'($urandom_range(0, 1)));
      if (roll < 95) return make_item(CMD_CLEAR, $urandom, 1'($urandom_range(0, 1)));
      return make_item(CMD_SPARE, $urandom, 1'($urandom_range(0, 1)));
   endfunction

   task automatic offer_item(input oms_req_type item);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.accept_request(item);
      items_sent++;
   endtask

   task automatic fill_store();
      while (board.held.size() < CAPACITY) begin
         if (board.held.size() > 0 && $urandom_range(0, 7) == 0)
            offer_item(make_item(CMD_VALUE, removal_value(), 1'b0));
         else
            offer_item(make_item(CMD_VALUE, pool_value(), 1'b1));
      end
      // overflow, then a removal from a full store
      repeat ($urandom_range(1, 3)) offer_item(make_item(CMD_VALUE, pool_value(), 1'b1));
      offer_item(make_item(CMD_VALUE, removal_value(), 1'b0));
      if ($urandom_range(0, 9) < 7)
         offer_item(make_item(CMD_FLUSH, $urandom, 1'($urandom_range(0, 1))));
      else
         offer_item(make_item(CMD_CLEAR, $urandom, 1'($urandom_range(0, 1))));
   endtask

   initial begin
      int  kind;
      bit  first_episode;
      common_values[0] = 32'h8000_0000;
      common_values[1] = 32'h7fff_ffff;
      common_values[2] = 32'h0000_0000;
      common_values[3] = 32'hffff_ffff;
      for (int i = 4; i < POOL_SIZE; i++) common_values[i] = $urandom;
      first_episode = 1'b1;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      offer_item(make_item(CMD_FLUSH, 32'h0, 1'b0));
      offer_item(make_item(CMD_VALUE, 32'h0, 1'b0));
      offer_item(make_item(CMD_VALUE, 32'h8000_0000, 1'b1));
      offer_item(make_item(CMD_VALUE, 32'h7fff_ffff, 1'b1));
      offer_item(make_item(CMD_VALUE, 32'h0000_0000, 1'b1));
      offer_item(make_item(CMD_VALUE, 32'hffff_ffff, 1'b1));
      offer_item(make_item(CMD_VALUE, 32'h7fff_ffff, 1'b1));
      offer_item(make_item(CMD_VALUE, 32'h0001_0000, 1'b1));
      // duplicate: only the oldest copy goes
      offer_item(make_item(CMD_VALUE, 32'h7fff_ffff, 1'b0));
      offer_item(make_item(CMD_VALUE, 32'h1234_5678, 1'b0));
      offer_item(make_item(CMD_SPARE, 32'hffff_ffff, 1'b1));
      offer_item(make_item(CMD_FLUSH, 32'hffff_ffff, 1'b1));
      offer_item(make_item(CMD_FLUSH, 32'h0, 1'b0));
      offer_item(make_item(CMD_VALUE, 32'h5555_5555, 1'b1));
      offer_item(make_item(CMD_VALUE, 32'haaaa_aaaa, 1'b1));
      offer_item(make_item(CMD_CLEAR, 32'haaaa_aaaa, 1'b1));
      offer_item(make_item(CMD_FLUSH, 32'h0, 1'b0));
      offer_item(make_item(CMD_VALUE, 32'h0001_8000, 1'b1));
      offer_item(make_item(CMD_VALUE, 32'h0001_8000, 1'b0));
      offer_item(make_item(CMD_VALUE, 32'hffff_0000, 1'b1));
      offer_item(make_item(CMD_FLUSH, 32'h5555_5555, 1'b0));
      offer_item(make_item(CMD_SPARE, 32'h0, 1'b0));

      while (items_sent < ITEM_TARGET) begin
         calm = ($urandom_range(0, 3) == 0);
         kind = first_episode ? 6 : $urandom_range(0, 9);
         first_episode = 1'b0;
         if (kind <= 5) begin
            repeat ($urandom_range(10, 30)) offer_item(random_item());
         end else if (kind <= 7) begin
            fill_store();
         end else if (kind == 8) begin
            repeat ($urandom_range(3, 8)) begin
               if ($urandom_range(0, 1))
                  offer_item(make_item(CMD_SPARE, $urandom, 1'($urandom_range(0, 1))));
               else
                  offer_item(make_item(CMD_VALUE, $urandom, 1'b0));
            end
         end else begin
            repeat ($urandom_range(1, 5)) offer_item(make_item(CMD_VALUE, pool_value(), 1'b1));
            offer_item(make_item(CMD_FLUSH, $urandom, 1'($urandom_range(0, 1))));
         end
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      while (board.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.awaited.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, board.awaited.size());
         board.errors++;
      end
      $display("sent %0d transactions; checked %0d results from %0d flush bursts",
               items_sent, board.results_seen, board.flush_bursts);
      $display("including %0d overflow drop reports", board.drop_reports);
      if (board.errors == 0)
         $display("ordered_multiset_store regression: pass");
      else
         $display("ordered_multiset_store regression: fail");
      $finish;
   end

endmodule
